// ===== rtl/gfq_pkg.sv =====
// Package for the gamepad frame qualifier: payload structs, lane status types,
// configuration register indexes, direction codes and sizing constants.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package gfq_pkg;

    // Sizing of the button history.
    localparam int HISTORY_FRAMES = 64;
    localparam int BUTTON_COUNT   = 16;
    localparam int HOLD_W         = $clog2(HISTORY_FRAMES + 1);
    localparam int HOLD_OUT_W     = 7;
    localparam int BTN_W          = 16;

    // Buttons past the configured count read as released.
    localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((64'd1 << BUTTON_COUNT) - 64'd1);

    // tan(22.5 deg) in Q16.
    localparam logic [15:0] TAN_Q16 = 16'd27146;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOCK_DZ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANY_STICK_DZ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INCL_STICK   = 2'd3;

    localparam logic [31:0] KNOCK_DZ_RST     = 32'd107374182;
    localparam logic [31:0] ANY_STICK_DZ_RST = 32'd107374182;
    localparam logic [7:0]  TRIG_THR_RST     = 8'd64;

    // Direction codes.
    localparam logic [3:0] DIR_NONE = 4'd0;
    localparam logic [3:0] DIR_L    = 4'd1;
    localparam logic [3:0] DIR_DL   = 4'd2;
    localparam logic [3:0] DIR_D    = 4'd3;
    localparam logic [3:0] DIR_DR   = 4'd4;
    localparam logic [3:0] DIR_R    = 4'd5;
    localparam logic [3:0] DIR_UR   = 4'd6;
    localparam logic [3:0] DIR_U    = 4'd7;
    localparam logic [3:0] DIR_UL   = 4'd8;

    typedef struct packed {
        logic [15:0]        button_bits;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [3:0]         query_button;
    } frame_t;

    typedef struct packed {
        logic [15:0] press_edges;
        logic [15:0] release_edges;
        logic [6:0]  hold_frames;
        logic        any_active;
        logic        any_rise;
        logic [3:0]  left_direction;
        logic [3:0]  right_direction;
        logic [3:0]  left_direction_change;
        logic [3:0]  right_direction_change;
    } result_t;

    // What one stick lane found for the frame in the second stage.
    typedef struct packed {
        logic [3:0] dir;
        logic       active;
    } stick_status_t;

    // Live configuration handed to the lanes and the merge stage.
    typedef struct packed {
        logic [31:0] knock_dz;
        logic [31:0] any_stick_dz;
        logic [7:0]  trig_thr;
        logic        incl_stick;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/gfq_stick_lane.sv =====
// One stick lane: squares and sector products registered in the first stage,
// dead-zone tests and the 8-way sector decision in the second stage.
// Depends on gfq_pkg.
`default_nettype none

module gfq_stick_lane (
    input  wire logic                   clk,
    input  wire logic                   load,
    input  wire logic signed [15:0]     x,
    input  wire logic signed [15:0]     y,
    input  wire logic [31:0]            knock_dz,
    input  wire logic [31:0]            any_stick_dz,
    output gfq_pkg::stick_status_t      status
);

    logic signed [31:0] xx_full;
    logic signed [31:0] yy_full;
    logic signed [16:0] x_neg;
    logic signed [16:0] y_neg;
    logic [15:0]        ax;
    logic [15:0]        ay;

    logic [30:0] xx_reg;
    logic [30:0] yy_reg;
    logic [31:0] ax_t_reg;
    logic [31:0] ay_t_reg;
    logic [15:0] ax_reg;
    logic [15:0] ay_reg;
    logic        x_pos_reg;
    logic        y_pos_reg;

    logic [31:0] mag_sq;
    logic        y_flat;
    logic        x_flat;
    logic [3:0]  sector;

    always_comb
    begin
        xx_full = 32'(x) * 32'(x);
        yy_full = 32'(y) * 32'(y);
        x_neg   = -{x[15], x};
        y_neg   = -{y[15], y};
        ax      = x[15] ? x_neg[15:0] : x;
        ay      = y[15] ? y_neg[15:0] : y;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xx_reg    <= xx_full[30:0];
            yy_reg    <= yy_full[30:0];
            ax_t_reg  <= 32'(ax * gfq_pkg::TAN_Q16);
            ay_t_reg  <= 32'(ay * gfq_pkg::TAN_Q16);
            ax_reg    <= ax;
            ay_reg    <= ay;
            x_pos_reg <= !x[15] && (x != 16'sd0);
            y_pos_reg <= !y[15] && (y != 16'sd0);
        end
    end

    always_comb
    begin
        mag_sq = {1'b0, xx_reg} + {1'b0, yy_reg};
        // Near the horizontal axis, then near the vertical axis, else a diagonal.
        y_flat = {ay_reg, 16'd0} < ax_t_reg;
        x_flat = {ax_reg, 16'd0} < ay_t_reg;
        if (y_flat)
        begin
            sector = x_pos_reg ? gfq_pkg::DIR_R : gfq_pkg::DIR_L;
        end
        else if (x_flat)
        begin
            sector = y_pos_reg ? gfq_pkg::DIR_U : gfq_pkg::DIR_D;
        end
        else if (x_pos_reg)
        begin
            sector = y_pos_reg ? gfq_pkg::DIR_UR : gfq_pkg::DIR_DR;
        end
        else
        begin
            sector = y_pos_reg ? gfq_pkg::DIR_UL : gfq_pkg::DIR_DL;
        end
        status.dir    = (mag_sq > knock_dz) ? sector : gfq_pkg::DIR_NONE;
        status.active = mag_sq > any_stick_dz;
    end

endmodule

`default_nettype wire

// ===== rtl/gfq_hold_lane.sv =====
// One button lane: the saturating consecutive-hold counter of a single button.
// Depends on gfq_pkg.
`default_nettype none

module gfq_hold_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        pressed,
    output logic [gfq_pkg::HOLD_W-1:0]       count_next
);

    logic [gfq_pkg::HOLD_W-1:0] count_reg;

    always_comb
    begin
        if (!pressed)
        begin
            count_next = '0;
        end
        else if (int'(count_reg) < gfq_pkg::HISTORY_FRAMES)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gfq_merge.sv =====
// Merge stage: combines the stick and button lanes with the previous-frame
// state into one result, and keeps that state. Depends on gfq_pkg.
`default_nettype none

module gfq_merge (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          advance,
    input  wire gfq_pkg::cfg_t                                 cfg,
    input  wire logic [15:0]                                   buttons,
    input  wire logic [7:0]                                    left_trigger,
    input  wire logic [7:0]                                    right_trigger,
    input  wire logic [3:0]                                    query_button,
    input  wire gfq_pkg::stick_status_t                        left_status,
    input  wire gfq_pkg::stick_status_t                        right_status,
    input  wire logic [gfq_pkg::BUTTON_COUNT-1:0][gfq_pkg::HOLD_W-1:0] hold_counts,
    output gfq_pkg::result_t                                   result_next
);

    logic [15:0] prev_buttons_reg;
    logic        prev_any_reg;
    logic [3:0]  prev_left_dir_reg;
    logic [3:0]  prev_right_dir_reg;
    logic [1:0]  frames_seen_reg;

    logic [gfq_pkg::HOLD_W-1:0]                    hold_sel;
    logic [gfq_pkg::HOLD_W+gfq_pkg::HOLD_OUT_W-1:0] hold_ext;
    logic                                          seen_one;
    logic                                          active;

    always_comb
    begin
        hold_sel = '0;
        for (int i = 0; i < gfq_pkg::BUTTON_COUNT; i++)
        begin
            if (int'(query_button) == i)
            begin
                hold_sel = hold_counts[i];
            end
        end
        hold_ext = {{gfq_pkg::HOLD_OUT_W{1'b0}}, hold_sel};

        seen_one = frames_seen_reg != 2'd0;
        active   = (buttons != 16'd0)
                || (left_trigger > cfg.trig_thr)
                || (right_trigger > cfg.trig_thr)
                || (cfg.incl_stick && (left_status.active || right_status.active));

        result_next.press_edges   = seen_one ? (buttons & ~prev_buttons_reg) : 16'd0;
        result_next.release_edges = seen_one ? (~buttons & prev_buttons_reg) : 16'd0;
        result_next.hold_frames   = hold_ext[gfq_pkg::HOLD_OUT_W-1:0];
        result_next.any_active    = active;
        result_next.any_rise      = frames_seen_reg[1] && active && !prev_any_reg;
        result_next.left_direction  = left_status.dir;
        result_next.right_direction = right_status.dir;
        result_next.left_direction_change =
            (seen_one && (left_status.dir != prev_left_dir_reg)) ? left_status.dir
                                                                  : gfq_pkg::DIR_NONE;
        result_next.right_direction_change =
            (seen_one && (right_status.dir != prev_right_dir_reg)) ? right_status.dir
                                                                    : gfq_pkg::DIR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg   <= 16'd0;
            prev_any_reg       <= 1'b0;
            prev_left_dir_reg  <= gfq_pkg::DIR_NONE;
            prev_right_dir_reg <= gfq_pkg::DIR_NONE;
            frames_seen_reg    <= 2'd0;
        end
        else if (advance)
        begin
            prev_buttons_reg   <= buttons;
            prev_any_reg       <= active;
            prev_left_dir_reg  <= left_status.dir;
            prev_right_dir_reg <= right_status.dir;
            if (frames_seen_reg != 2'd3)
            begin
                frames_seen_reg <= frames_seen_reg + 2'd1;
            end
        end
    end

    a_first_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (frames_seen_reg == 2'd0) |-> (result_next.press_edges == 16'd0
            && result_next.release_edges == 16'd0
            && result_next.left_direction_change == gfq_pkg::DIR_NONE
            && result_next.right_direction_change == gfq_pkg::DIR_NONE))
        else $error("edges reported on the first frame");

    a_rise_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
        result_next.any_rise |-> (frames_seen_reg[1] && result_next.any_active))
        else $error("any_rise without two earlier frames or without any_active");

    a_change_matches_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (result_next.left_direction_change != gfq_pkg::DIR_NONE)
            |-> (result_next.left_direction_change == left_status.dir))
        else $error("left direction change differs from the direction");

    a_frames_counted: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (frames_seen_reg != 2'd0))
        else $error("frame count did not move after a frame");

endmodule

`default_nettype wire

// ===== rtl/gamepad_frame_qualifier_top.sv =====
// Top level of the gamepad frame qualifier: channel handshakes, configuration
// registers, the two stick lanes, the button lanes and the merge stage.
// Depends on gfq_pkg, gfq_stick_lane, gfq_hold_lane and gfq_merge.
`default_nettype none

// Channel   Direction  Handshake                        Payload
// frame     in         frame_valid / frame_ready        gfq_pkg::frame_t
// result    out        result_valid / result_ready      gfq_pkg::result_t
// config    in         cfg_we (no wait)                 cfg_index, cfg_data
//
// On the way from transfer to result, the first stage registers
// the stick squares and sector products, the second stage runs the dead-zone and
// sector compares, the hold counters and the merge into the output register.
// One frame is taken every cycle while the result side does not stall. Reset
// clears the history and loads the register defaults; no clearing pass is
// needed. A stall on the result side holds both stages.

module gamepad_frame_qualifier_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               frame_valid,
    output logic                                    frame_ready,
    input  wire gfq_pkg::frame_t                    frame,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output gfq_pkg::result_t                        result,
    input  wire logic                               cfg_we,
    input  wire logic [gfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    gfq_pkg::cfg_t cfg_reg;

    // First stage: the frame fields that do not go through a stick lane.
    logic        a_valid_reg;
    logic [15:0] a_buttons_reg;
    logic [7:0]  a_left_trig_reg;
    logic [7:0]  a_right_trig_reg;
    logic [3:0]  a_query_reg;

    // Output register.
    logic             result_valid_reg;
    gfq_pkg::result_t result_reg;

    logic                  out_free;
    logic                  advance;
    logic                  accept;
    gfq_pkg::stick_status_t left_status;
    gfq_pkg::stick_status_t right_status;
    gfq_pkg::result_t      result_next;
    logic [gfq_pkg::BUTTON_COUNT-1:0][gfq_pkg::HOLD_W-1:0] hold_counts;

    // The output register frees up when it is empty or its result transfers;
    // the first stage moves forward whenever the output register is free.
    assign out_free     = !result_valid_reg || result_ready;
    assign advance      = a_valid_reg && out_free;
    assign frame_ready  = !a_valid_reg || out_free;
    assign accept       = frame_valid && frame_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.knock_dz     <= gfq_pkg::KNOCK_DZ_RST;
            cfg_reg.any_stick_dz <= gfq_pkg::ANY_STICK_DZ_RST;
            cfg_reg.trig_thr     <= gfq_pkg::TRIG_THR_RST;
            cfg_reg.incl_stick   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gfq_pkg::CFG_KNOCK_DZ:     cfg_reg.knock_dz     <= cfg_data[31:0];
                gfq_pkg::CFG_ANY_STICK_DZ: cfg_reg.any_stick_dz <= cfg_data[31:0];
                gfq_pkg::CFG_TRIG_THR:     cfg_reg.trig_thr     <= cfg_data[7:0];
                gfq_pkg::CFG_INCL_STICK:   cfg_reg.incl_stick   <= cfg_data[0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_ready)
            begin
                a_valid_reg <= frame_valid;
            end
            if (out_free)
            begin
                result_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_buttons_reg    <= frame.button_bits & gfq_pkg::BTN_MASK;
            a_left_trig_reg  <= frame.left_trigger;
            a_right_trig_reg <= frame.right_trigger;
            a_query_reg      <= frame.query_button;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    gfq_stick_lane u_left_lane (
        .clk          (clk),
        .load         (accept),
        .x            (frame.left_x),
        .y            (frame.left_y),
        .knock_dz     (cfg_reg.knock_dz),
        .any_stick_dz (cfg_reg.any_stick_dz),
        .status       (left_status)
    );

    gfq_stick_lane u_right_lane (
        .clk          (clk),
        .load         (accept),
        .x            (frame.right_x),
        .y            (frame.right_y),
        .knock_dz     (cfg_reg.knock_dz),
        .any_stick_dz (cfg_reg.any_stick_dz),
        .status       (right_status)
    );

    // One hold counter lane per button; buttons past the field width never press.
    for (genvar i = 0; i < gfq_pkg::BUTTON_COUNT; i++)
    begin : g_hold
        logic pressed;
        if (i < gfq_pkg::BTN_W)
        begin : g_in
            assign pressed = a_buttons_reg[i];
        end
        else
        begin : g_out
            assign pressed = 1'b0;
        end

        gfq_hold_lane u_hold (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .pressed    (pressed),
            .count_next (hold_counts[i])
        );
    end

    gfq_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cfg           (cfg_reg),
        .buttons       (a_buttons_reg),
        .left_trigger  (a_left_trig_reg),
        .right_trigger (a_right_trig_reg),
        .query_button  (a_query_reg),
        .left_status   (left_status),
        .right_status  (right_status),
        .hold_counts   (hold_counts),
        .result_next   (result_next)
    );

endmodule

`default_nettype wire
